[design/rnfa_pkg.sv]
// shared types, codes and defaults for the postfix regex to nfa edge builder
// no dependencies
`timescale 1ns / 1ps

package rnfa_pkg;

    localparam int DEF_MAX_STATES  = 256;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int OP_QUEUE_DEPTH  = 4;
    localparam int RESULT_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;

    localparam logic [1:0] KIND_EDGE   = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_LEAF_SYM = 3'd1;
    localparam logic [2:0] OP_LEAF_EPS = 3'd2;
    localparam logic [2:0] OP_CAT      = 3'd3;
    localparam logic [2:0] OP_ALT      = 3'd4;
    localparam logic [2:0] OP_STAR     = 3'd5;

    typedef struct packed {
        logic [7:0] symbol_char;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] from_state;
        logic [7:0] to_state;
        logic       is_epsilon;
        logic [7:0] edge_symbol;
        logic       found;
        logic       last_result;
    } out_item_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] sym;
        logic       last;
    } op_item_t;

endpackage

[design/rnfa_fifo.sv]
// small register fifo used between front and back and on the result side
// depends on nothing but its type parameter
`timescale 1ns / 1ps

module rnfa_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    T              slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/rnfa_front.sv]
// front end: takes characters, tracks escapes and classifies each one into an op
// depends on rnfa_pkg
`timescale 1ns / 1ps

module rnfa_front
    import rnfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    output logic     op_wr,
    output op_item_t op_data,
    input  logic     op_full
);

    logic escape_reg;
    logic escape_next;
    logic accept;
    logic [2:0] op_code;

    assign full   = op_full;
    assign accept = push && !op_full;

    always_comb
    begin
        op_code = OP_LEAF_SYM;
        if (!escape_reg)
        begin
            case (item.symbol_char)
                CH_BSLASH: op_code = OP_NONE;
                CH_DOT:    op_code = OP_CAT;
                CH_BAR:    op_code = OP_ALT;
                CH_STAR:   op_code = OP_STAR;
                CH_HASH:   op_code = OP_LEAF_EPS;
                default:   op_code = OP_LEAF_SYM;
            endcase
        end
    end

    // a lone backslash that is not last makes no transaction downstream
    assign op_wr        = accept && !((op_code == OP_NONE) && !item.last_char);
    assign op_data.op   = op_code;
    assign op_data.sym  = item.symbol_char;
    assign op_data.last = item.last_char;

    always_comb
    begin
        escape_next = escape_reg;
        if (accept)
        begin
            escape_next = !escape_reg && (item.symbol_char == CH_BSLASH) && !item.last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
        end
        else
        begin
            escape_reg <= escape_next;
        end
    end

endmodule

[design/rnfa_back.sv]
// back end: fragment stack, state counter and edge emission for each op
// depends on rnfa_pkg
`timescale 1ns / 1ps

module rnfa_back
    import rnfa_pkg::*;
#(
    parameter int MAX_STATES  = DEF_MAX_STATES,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    input  op_item_t  op_data,
    output logic      op_pop,
    output logic      res_wr,
    output out_item_t res_data,
    input  logic      res_full
);

    localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CW = $clog2(MAX_STATES + 1);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic            state_reg;
    logic            state_next;
    op_item_t        op_reg;
    logic [2:0]      idx_reg;
    logic [2:0]      idx_next;
    logic [DW-1:0]   depth_reg;
    logic [DW-1:0]   depth_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [SW-1:0]   top_s_reg;
    logic [SW-1:0]   top_s_next;
    logic [SW-1:0]   top_e_reg;
    logic [SW-1:0]   top_e_next;
    logic [2*SW-1:0] mem [STACK_DEPTH];
    logic [2*SW-1:0] rd_reg;

    logic [SW-1:0]   rd_s;
    logic [SW-1:0]   rd_e;
    logic [SW-1:0]   s_id;
    logic [SW-1:0]   e_id;
    logic            room;
    logic            has1;
    logic            has2;
    logic            at_full;
    logic [2:0]      n_body;
    logic            body_err;
    logic            body_ok;
    logic            do_push;
    logic [2:0]      total;
    logic            done;
    logic [DW-1:0]   nd;
    logic [SW-1:0]   nts;
    logic [SW-1:0]   nte;
    logic [SW-1:0]   e_from;
    logic [SW-1:0]   e_to;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            mem_we;

    assign rd_s    = rd_reg[2*SW-1:SW];
    assign rd_e    = rd_reg[SW-1:0];
    assign s_id    = SW'(cnt_reg);
    assign e_id    = SW'(cnt_reg + CW'(1));
    assign room    = (cnt_reg <= CW'(MAX_STATES - 2));
    assign has1    = (depth_reg != '0);
    assign has2    = (depth_reg >= DW'(2));
    assign at_full = (depth_reg == DW'(STACK_DEPTH));
    assign rd_addr = AW'(depth_reg - DW'(2));
    assign wr_addr = AW'(depth_reg - DW'(1));

    // op plan and the stack after it
    always_comb
    begin
        n_body   = 3'd0;
        body_err = 1'b0;
        body_ok  = 1'b0;
        do_push  = 1'b0;
        nd       = depth_reg;
        nts      = top_s_reg;
        nte      = top_e_reg;
        case (op_reg.op)
            OP_LEAF_SYM, OP_LEAF_EPS:
            begin
                n_body = 3'd1;
                if (!room || at_full)
                begin
                    body_err = 1'b1;
                end
                else
                begin
                    body_ok = 1'b1;
                    do_push = has1;
                    nd      = depth_reg + DW'(1);
                    nts     = s_id;
                    nte     = e_id;
                end
            end
            OP_CAT:
            begin
                if (has2)
                begin
                    n_body  = 3'd1;
                    body_ok = 1'b1;
                    nd      = depth_reg - DW'(1);
                    nts     = rd_s;
                end
            end
            OP_ALT:
            begin
                if (has2)
                begin
                    if (!room)
                    begin
                        n_body   = 3'd1;
                        body_err = 1'b1;
                    end
                    else
                    begin
                        n_body  = 3'd4;
                        body_ok = 1'b1;
                        nd      = depth_reg - DW'(1);
                        nts     = s_id;
                        nte     = e_id;
                    end
                end
            end
            OP_STAR:
            begin
                if (has1)
                begin
                    if (!room)
                    begin
                        n_body   = 3'd1;
                        body_err = 1'b1;
                    end
                    else
                    begin
                        n_body  = 3'd4;
                        body_ok = 1'b1;
                        nts     = s_id;
                        nte     = e_id;
                    end
                end
            end
            default:
            begin
                n_body = 3'd0;
            end
        endcase
    end

    // endpoints of edge number idx_reg
    always_comb
    begin
        e_from = s_id;
        e_to   = e_id;
        case (op_reg.op)
            OP_CAT:
            begin
                e_from = rd_e;
                e_to   = top_s_reg;
            end
            OP_ALT:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        e_from = s_id;
                        e_to   = rd_s;
                    end
                    3'd1:
                    begin
                        e_from = s_id;
                        e_to   = top_s_reg;
                    end
                    3'd2:
                    begin
                        e_from = rd_e;
                        e_to   = e_id;
                    end
                    default:
                    begin
                        e_from = top_e_reg;
                        e_to   = e_id;
                    end
                endcase
            end
            OP_STAR:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        e_from = s_id;
                        e_to   = top_s_reg;
                    end
                    3'd1:
                    begin
                        e_from = s_id;
                        e_to   = e_id;
                    end
                    3'd2:
                    begin
                        e_from = top_e_reg;
                        e_to   = top_s_reg;
                    end
                    default:
                    begin
                        e_from = top_e_reg;
                        e_to   = e_id;
                    end
                endcase
            end
            default:
            begin
                e_from = s_id;
                e_to   = e_id;
            end
        endcase
    end

    assign total = n_body + {2'b00, op_reg.last};

    always_comb
    begin
        res_data             = '0;
        res_data.last_result = (idx_reg == total - 3'd1);
        if (idx_reg == n_body)
        begin
            res_data.kind = KIND_REPORT;
            if (nd != '0)
            begin
                res_data.from_state = 8'(nts);
                res_data.to_state   = 8'(nte);
                res_data.found      = 1'b1;
            end
        end
        else if (body_err)
        begin
            res_data.kind = KIND_ERROR;
        end
        else
        begin
            res_data.kind       = KIND_EDGE;
            res_data.from_state = 8'(e_from);
            res_data.to_state   = 8'(e_to);
            if (op_reg.op == OP_LEAF_SYM)
            begin
                res_data.edge_symbol = op_reg.sym;
            end
            else
            begin
                res_data.is_epsilon = 1'b1;
            end
        end
    end

    assign op_pop = (state_reg == ST_IDLE) && op_valid;
    assign res_wr = (state_reg == ST_EXEC) && (total != 3'd0) && !res_full;
    assign done   = (state_reg == ST_EXEC)
                    && ((total == 3'd0) || (!res_full && (idx_reg == total - 3'd1)));
    assign mem_we = done && do_push;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        depth_next = depth_reg;
        cnt_next   = cnt_reg;
        top_s_next = top_s_reg;
        top_e_next = top_e_reg;
        if (op_pop)
        begin
            state_next = ST_EXEC;
            idx_next   = 3'd0;
        end
        else if (done)
        begin
            state_next = ST_IDLE;
            if (op_reg.last)
            begin
                depth_next = '0;
                cnt_next   = '0;
            end
            else if (body_ok)
            begin
                depth_next = nd;
                top_s_next = nts;
                top_e_next = nte;
                if (op_reg.op != OP_CAT)
                begin
                    cnt_next = cnt_reg + CW'(2);
                end
            end
        end
        else if (res_wr)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 3'd0;
            depth_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            depth_reg <= depth_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_s_reg <= top_s_next;
        top_e_reg <= top_e_next;
        if (op_pop)
        begin
            op_reg <= op_data;
        end
    end

    // stack body below the cached top, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {top_s_reg, top_e_reg};
        end
        rd_reg <= mem[rd_addr];
    end

endmodule

[design/postfix_regex_to_nfa_edges_top.sv]
// channel   direction  handshake          payload
// item      in         push / full        in_item_t  (symbol_char, last_char)
// result    out        pop / empty        out_item_t (kind, states, label, flags)
//
// the back end runs one op at a time: it fetches the op and the second
// stack entry, then gives one result per cycle while the result queue has room;
// a leaf or concat gives one edge, alternation or star four and an error one;
// a last character adds a report; a non-final backslash never reaches the back end
// rst_n clears the counter, stack depth, escape flag and both queues; no sweep
// input and output stall independently through the op queue and result queue
// depends on rnfa_pkg, rnfa_fifo, rnfa_front, rnfa_back
`timescale 1ns / 1ps

module postfix_regex_to_nfa_edges_top
    import rnfa_pkg::*;
#(
    parameter int MAX_STATES  = DEF_MAX_STATES,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  item,
    output logic      full,
    input  logic      pop,
    output out_item_t result,
    output logic      empty
);

    logic      op_wr;
    op_item_t  op_wdata;
    logic      op_full;
    logic      op_empty;
    op_item_t  op_rdata;
    logic      op_pop;
    logic      res_wr;
    out_item_t res_wdata;
    logic      res_full;

    rnfa_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .op_wr   (op_wr),
        .op_data (op_wdata),
        .op_full (op_full)
    );

    rnfa_fifo #(
        .T     (op_item_t),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_wr),
        .wr_data (op_wdata),
        .full    (op_full),
        .rd_en   (op_pop),
        .rd_data (op_rdata),
        .empty   (op_empty)
    );

    rnfa_back #(
        .MAX_STATES  (MAX_STATES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!op_empty),
        .op_data  (op_rdata),
        .op_pop   (op_pop),
        .res_wr   (res_wr),
        .res_data (res_wdata),
        .res_full (res_full)
    );

    rnfa_fifo #(
        .T     (out_item_t),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_wdata),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
